### rtl/m3i_pkg.sv
`default_nettype none
package m3i_pkg;

  // Fixed field widths
  localparam int unsigned ElemW     = 16;
  localparam int unsigned DetOutW   = 48;
  localparam int unsigned ProdW     = 2 * ElemW;       // entry x entry
  localparam int unsigned AdjW      = ProdW + 1;       // difference of two products
  localparam int unsigned DetProdW  = ElemW + AdjW;    // entry x cofactor
  localparam int unsigned DetW      = DetProdW + 1;    // sum of three, exact
  localparam int unsigned QuotW     = 17;              // quotient bits kept before clamp
  localparam int unsigned NumEntries = 9;
  localparam int unsigned DefFracBits = 8;

  typedef logic [3:0] idx_t;

  // Adjugate entry k = m[p0]*m[p1] - m[p2]*m[p3], row-major m[3*i+j]
  localparam idx_t AdjIdx [NumEntries][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  typedef logic signed [ElemW-1:0] elem_t;
  typedef logic signed [AdjW-1:0]  adj_t;
  typedef logic signed [DetW-1:0]  det_t;

  typedef struct packed {
    logic signed [ElemW-1:0] a00;
    logic signed [ElemW-1:0] a01;
    logic signed [ElemW-1:0] a02;
    logic signed [ElemW-1:0] a10;
    logic signed [ElemW-1:0] a11;
    logic signed [ElemW-1:0] a12;
    logic signed [ElemW-1:0] a20;
    logic signed [ElemW-1:0] a21;
    logic signed [ElemW-1:0] a22;
  } mat_t;

  typedef struct packed {
    logic signed [ElemW-1:0]   r00;
    logic signed [ElemW-1:0]   r01;
    logic signed [ElemW-1:0]   r02;
    logic signed [ElemW-1:0]   r10;
    logic signed [ElemW-1:0]   r11;
    logic signed [ElemW-1:0]   r12;
    logic signed [ElemW-1:0]   r20;
    logic signed [ElemW-1:0]   r21;
    logic signed [ElemW-1:0]   r22;
    logic signed [DetOutW-1:0] determinant;
    logic                      singular;
  } res_t;

endpackage
`default_nettype wire

### rtl/m3i_if.sv
`default_nettype none
interface m3i_mat_if;
  logic          valid;
  logic          ready;
  m3i_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface m3i_res_if;
  logic          valid;
  logic          ready;
  m3i_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### rtl/m3i_cofactor.sv
`default_nettype none
// Cofactors and exact determinant, four register stages.
module m3i_cofactor (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire m3i_pkg::elem_t m_i   [m3i_pkg::NumEntries],
  output m3i_pkg::adj_t       adj_o [m3i_pkg::NumEntries],
  output m3i_pkg::det_t       det_o
);
  import m3i_pkg::*;

  logic signed [ProdW-1:0]    prod_a_q [NumEntries];
  logic signed [ProdW-1:0]    prod_b_q [NumEntries];
  elem_t                      row0_s1_q [3];
  elem_t                      row0_s2_q [3];
  adj_t                       adj_s2_q [NumEntries];
  adj_t                       adj_s3_q [NumEntries];
  adj_t                       adj_s4_q [NumEntries];
  logic signed [DetProdW-1:0] dprod_q [3];
  det_t                       det_q;

  // stage 1: entry products, stage 2: cofactors
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NumEntries; k++) begin
        prod_a_q[k] <= m_i[AdjIdx[k][0]] * m_i[AdjIdx[k][1]];
        prod_b_q[k] <= m_i[AdjIdx[k][2]] * m_i[AdjIdx[k][3]];
        adj_s2_q[k] <= AdjW'(prod_a_q[k]) - AdjW'(prod_b_q[k]);
        adj_s3_q[k] <= adj_s2_q[k];
        adj_s4_q[k] <= adj_s3_q[k];
      end
      for (int j = 0; j < 3; j++) begin
        row0_s1_q[j] <= m_i[j];
        row0_s2_q[j] <= row0_s1_q[j];
      end
    end
  end

  // stage 3: first-row expansion terms, stage 4: sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dprod_q[0] <= row0_s2_q[0] * adj_s2_q[0];
      dprod_q[1] <= row0_s2_q[1] * adj_s2_q[3];
      dprod_q[2] <= row0_s2_q[2] * adj_s2_q[6];
      det_q      <= DetW'(dprod_q[0]) + DetW'(dprod_q[1]) + DetW'(dprod_q[2]);
    end
  end

  assign adj_o = adj_s4_q;
  assign det_o = det_q;

endmodule
`default_nettype wire

### rtl/m3i_div_lane.sv
`default_nettype none
// One inverse entry: rounded adj * 2^(2F) / det, restoring divider,
// one quotient bit per stage.
module m3i_div_lane #(
  parameter int unsigned FRAC_BITS = m3i_pkg::DefFracBits
) (
  input  wire logic           clk_i,
  input  wire logic           en_i,
  input  wire m3i_pkg::adj_t  adj_i,
  input  wire m3i_pkg::det_t  det_i,
  output logic signed [m3i_pkg::ElemW-1:0] inv_o
);
  import m3i_pkg::*;

  localparam int unsigned MagW = ProdW;                 // |adj| <= 2^31
  localparam int unsigned NumW = MagW + 2 * FRAC_BITS;
  localparam int unsigned DenW = DetOutW + 1;           // 2*|det|
  localparam int unsigned NW   = (NumW + 2 > DenW) ? NumW + 2 : DenW + 1;
  localparam int unsigned RemW = DenW + 1;

  logic [MagW-1:0]    adj_mag;
  logic [DetW-1:0]    det_neg;
  logic [DetOutW-1:0] det_mag;
  logic [DenW-1:0]    den;
  logic [NW-1:0]      numer;
  logic [NW-1:0]      numer_hi;

  logic [RemW-1:0]  rem_q  [QuotW+1];
  logic [QuotW-1:0] low_q  [QuotW+1];
  logic [QuotW-1:0] quo_q  [QuotW+1];
  logic [DenW-1:0]  den_q  [QuotW+1];
  logic             neg_q  [QuotW+1];
  logic             ovf_q  [QuotW+1];
  logic             zero_q [QuotW+1];

  // operand prep: magnitudes, rounding offset, range check
  always_comb begin
    adj_mag  = adj_i[AdjW-1] ? MagW'(-adj_i) : MagW'(adj_i);
    det_neg  = -det_i;
    det_mag  = det_i[DetW-1] ? det_neg[DetOutW-1:0] : det_i[DetOutW-1:0];
    den      = {det_mag, 1'b0};
    numer    = NW'({adj_mag, {(2 * FRAC_BITS + 1){1'b0}}}) + NW'(det_mag);
    numer_hi = numer >> QuotW;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= RemW'(numer_hi);
      low_q[0]  <= numer[QuotW-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den;
      neg_q[0]  <= adj_i[AdjW-1] ^ det_i[DetW-1];
      ovf_q[0]  <= numer_hi >= NW'(den);
      zero_q[0] <= det_i == '0;
    end
  end

  // quotient steps
  for (genvar s = 1; s <= QuotW; s++) begin : g_step
    logic [RemW-1:0] trial;
    logic            fits;
    assign trial = {rem_q[s-1][RemW-2:0], low_q[s-1][QuotW-1]};
    assign fits  = trial >= RemW'(den_q[s-1]);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s]  <= fits ? trial - RemW'(den_q[s-1]) : trial;
        low_q[s]  <= {low_q[s-1][QuotW-2:0], 1'b0};
        quo_q[s]  <= {quo_q[s-1][QuotW-2:0], fits};
        den_q[s]  <= den_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        ovf_q[s]  <= ovf_q[s-1];
        zero_q[s] <= zero_q[s-1];
      end
    end
  end

  // sign, clamp, singular zero
  logic [QuotW-1:0] q_fin;
  logic [QuotW-1:0] q_clamp;
  logic [QuotW-1:0] q_negd;
  logic [ElemW-1:0] inv_d;

  always_comb begin
    q_fin  = quo_q[QuotW];
    if (neg_q[QuotW]) begin
      q_clamp = (ovf_q[QuotW] || q_fin > QuotW'(32768)) ? QuotW'(32768) : q_fin;
      q_negd  = -q_clamp;
      inv_d   = q_negd[ElemW-1:0];
    end else begin
      q_clamp = (ovf_q[QuotW] || q_fin > QuotW'(32767)) ? QuotW'(32767) : q_fin;
      q_negd  = q_clamp;
      inv_d   = q_clamp[ElemW-1:0];
    end
    if (zero_q[QuotW]) begin
      inv_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      inv_o <= inv_d;
    end
  end

endmodule
`default_nettype wire

### rtl/matrix3_inverse_determinant_unit.sv
`default_nettype none
// Channel  | dir | beat contents
// mat_i    | in  | a00..a22, Q(16-F).F signed
// res_o    | out | r00..r22 Q(16-F).F, determinant Q.3F (48b), singular
//
// One beat accepted per cycle while the pipeline is not stalled.
// The restoring divider produces one quotient bit per stage, with
// nine divider lanes side by side, one per inverse entry.
// The whole pipeline advances together; it stalls only when the output
// register holds a beat that is not taken. Reset clears the valid chain only.
module matrix3_inverse_determinant_unit #(
  parameter int unsigned FRAC_BITS = m3i_pkg::DefFracBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  m3i_mat_if.sink   mat_i,
  m3i_res_if.source res_o
);
  import m3i_pkg::*;

  localparam int unsigned FrontLat = 4;
  localparam int unsigned LaneLat  = QuotW + 2;
  localparam int unsigned Lat      = FrontLat + LaneLat;

  logic              en;
  logic [Lat-1:0]    vld_q;
  elem_t             m    [NumEntries];
  adj_t              adj  [NumEntries];
  det_t              det;
  logic [ElemW-1:0]  inv  [NumEntries];
  logic [DetOutW-1:0] det_sat;
  logic [DetOutW-1:0] det_dly_q  [LaneLat];
  logic               zero_dly_q [LaneLat];

  assign en          = !vld_q[Lat-1] || res_o.ready;
  assign mat_i.ready = en;

  assign m[0] = mat_i.data.a00;
  assign m[1] = mat_i.data.a01;
  assign m[2] = mat_i.data.a02;
  assign m[3] = mat_i.data.a10;
  assign m[4] = mat_i.data.a11;
  assign m[5] = mat_i.data.a12;
  assign m[6] = mat_i.data.a20;
  assign m[7] = mat_i.data.a21;
  assign m[8] = mat_i.data.a22;

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], mat_i.valid};
    end
  end

  m3i_cofactor u_cofactor (
    .clk_i (clk_i),
    .en_i  (en),
    .m_i   (m),
    .adj_o (adj),
    .det_o (det)
  );

  for (genvar k = 0; k < NumEntries; k++) begin : g_lane
    m3i_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .adj_i (adj[k]),
      .det_i (det),
      .inv_o (inv[k])
    );
  end

  // determinant clamp to 48 bits, delayed alongside the lanes
  always_comb begin
    if (det[DetW-1:DetOutW-1] == '0 || det[DetW-1:DetOutW-1] == '1) begin
      det_sat = det[DetOutW-1:0];
    end else if (det[DetW-1]) begin
      det_sat = {1'b1, {(DetOutW-1){1'b0}}};
    end else begin
      det_sat = {1'b0, {(DetOutW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_dly_q[0]  <= det_sat;
      zero_dly_q[0] <= det == '0;
      for (int s = 1; s < LaneLat; s++) begin
        det_dly_q[s]  <= det_dly_q[s-1];
        zero_dly_q[s] <= zero_dly_q[s-1];
      end
    end
  end

  assign res_o.valid            = vld_q[Lat-1];
  assign res_o.data.r00         = inv[0];
  assign res_o.data.r01         = inv[1];
  assign res_o.data.r02         = inv[2];
  assign res_o.data.r10         = inv[3];
  assign res_o.data.r11         = inv[4];
  assign res_o.data.r12         = inv[5];
  assign res_o.data.r20         = inv[6];
  assign res_o.data.r21         = inv[7];
  assign res_o.data.r22         = inv[8];
  assign res_o.data.determinant = det_dly_q[LaneLat-1];
  assign res_o.data.singular    = zero_dly_q[LaneLat-1];

`ifndef NO_ASSERTIONS
  a_idle_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[Lat-1] |-> mat_i.ready)
    else $error("input stalled with empty output stage");

  a_sing_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.data.singular) |->
      (res_o.data.determinant == '0 && res_o.data.r00 == '0 &&
       res_o.data.r11 == '0 && res_o.data.r22 == '0))
    else $error("singular beat carries nonzero values");

  a_nonsing_det : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.data.singular) |-> res_o.data.determinant != '0)
    else $error("nonsingular beat with zero determinant");

  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.ready) |=> $stable(vld_q))
    else $error("pipeline moved during output stall");
`endif

endmodule
`default_nettype wire
